[hw/rtl/spw_pkg.sv]
// ----------------------------------------------------------------------------
// spw_pkg
// Shared types, register codes and CRC-8 helpers for the SMBus read-word
// PEC checker.
// ----------------------------------------------------------------------------
package spw_pkg;

  localparam logic [7:0] CrcPoly      = 8'h07;
  localparam logic [6:0] AddrReset    = 7'd0;
  localparam logic [7:0] CmdReset     = 8'h07;

  typedef enum logic [0:0] {
    REG_SLAVE_ADDRESS = 1'b0,
    REG_COMMAND_CODE  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct packed {
    logic [15:0] data_word;
    logic        pec_error;
    logic [7:0]  computed_pec;
  } res_item_t;

  typedef struct packed {
    cfg_reg_e   index;
    logic [7:0] wdata;
  } cfg_item_t;

  // One byte of CRC-8, MSB first, no reflection. Synthesis turns the
  // eight shift steps into a flat XOR network.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  // CRC over the three prefix bytes: write address, command, write address.
  function automatic logic [7:0] prefix_crc(input logic [6:0] addr, input logic [7:0] cmd);
    logic [7:0] a;
    logic [7:0] c;
    a = {addr, 1'b0};
    c = crc8_byte(8'h00, a);
    c = crc8_byte(c, cmd);
    c = crc8_byte(c, a);
    return c;
  endfunction

endpackage

[hw/rtl/spw_chan_if.sv]
// ----------------------------------------------------------------------------
// spw_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface spw_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/spw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// spw_cfg_regs
// Address and command registers, plus the CRC of the message prefix, which
// is updated at the same edge as the registers it depends on.
// ----------------------------------------------------------------------------
module spw_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  spw_pkg::cfg_item_t cfg_item_i,
  output logic [7:0]        prefix_crc_o
);
  import spw_pkg::*;

  logic [6:0] addr_q, addr_d;
  logic [7:0] cmd_q, cmd_d;
  logic [7:0] prefix_q, prefix_d;

  always_comb begin
    addr_d = addr_q;
    cmd_d  = cmd_q;
    if (cfg_valid_i) begin
      case (cfg_item_i.index)
        REG_SLAVE_ADDRESS: addr_d = cfg_item_i.wdata[6:0];
        REG_COMMAND_CODE:  cmd_d  = cfg_item_i.wdata;
        default: ;
      endcase
    end
    prefix_d = prefix_crc(addr_d, cmd_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= AddrReset;
      cmd_q    <= CmdReset;
      prefix_q <= prefix_crc(AddrReset, CmdReset);
    end else begin
      addr_q   <= addr_d;
      cmd_q    <= cmd_d;
      prefix_q <= prefix_d;
    end
  end

  assign prefix_crc_o = prefix_q;

endmodule

[hw/rtl/spw_pec_core.sv]
// ----------------------------------------------------------------------------
// spw_pec_core
// Input register, byte-position tracking with running CRC, and result
// register for the read-word PEC check.
// ----------------------------------------------------------------------------
module spw_pec_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          prefix_crc_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spw_pkg::rx_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spw_pkg::res_item_t  out_item_o
);
  import spw_pkg::*;

  typedef enum logic [1:0] {
    POS_LOW  = 2'd0,
    POS_HIGH = 2'd1,
    POS_PEC  = 2'd2
  } pos_e;

  logic      in_vld_q;
  rx_item_t  in_q;
  pos_e      pos_q, pos_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] low_q, high_q;
  logic      out_vld_q;
  res_item_t out_q;

  logic      start_new;
  logic      is_pec;
  logic      adv;
  logic [7:0] crc_next;
  logic      mismatch;

  always_comb begin
    start_new = in_q.frame_start;
    is_pec    = 1'b0;
    pos_d     = pos_q;
    case (pos_q)
      POS_LOW:  start_new = 1'b1;
      POS_HIGH: ;
      POS_PEC:  is_pec = !in_q.frame_start;
      default:  start_new = 1'b1;
    endcase

    crc_next = crc8_byte(start_new ? prefix_crc_i : crc_q, in_q.rx_byte);
    mismatch = (in_q.rx_byte != crc_q);

    // A PEC byte needs the result register; other bytes always move on.
    adv = in_vld_q && (!is_pec || !out_vld_q || out_ready_i);

    crc_d = crc_q;
    if (adv) begin
      if (start_new) begin
        pos_d = POS_HIGH;
        crc_d = crc_next;
      end else if (is_pec) begin
        pos_d = POS_LOW;
      end else begin
        pos_d = POS_PEC;
        crc_d = crc_next;
      end
    end
  end

  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pos_q     <= POS_LOW;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      pos_q <= pos_d;
      if (adv && is_pec) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    crc_q <= crc_d;
    if (adv && start_new) begin
      low_q <= in_q.rx_byte;
    end
    if (adv && !start_new && !is_pec) begin
      high_q <= in_q.rx_byte;
    end
    if (adv && is_pec) begin
      out_q.data_word    <= mismatch ? 16'h0000 : {high_q, low_q};
      out_q.pec_error    <= mismatch;
      out_q.computed_pec <= crc_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

[hw/rtl/smbus_pec_word_checker_unit.sv]
// ----------------------------------------------------------------------------
// smbus_pec_word_checker_unit
// Checks the PEC of an SMBus read-word response, one received byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   rx_if carries the response bytes in order: low data, high data, PEC.
//   frame_start marks a byte as the low byte of a new response and drops
//   any partial response without a result.
//   res_if gives one item per PEC byte: the data word (zero on mismatch),
//   the error flag and the CRC-8 computed over address, command, address,
//   low and high bytes.
//   cfg_if writes the slave address (index 0) and the command code
//   (index 1); it is always ready. Write it only while no response is open.
// Timing:
//   One byte is accepted every cycle while no PEC byte waits in the input
//   register for the result register to free up. A result becomes valid
//   when its PEC byte moves from the input register into the result
//   register; these are the two stages, with one CRC byte step between them.
// Reset and stall:
//   Reset sets address 0, command 7 and expects a low byte. While the
//   receiver holds off a result, one more PEC byte can wait in the input
//   register and data bytes keep flowing until then.
// ----------------------------------------------------------------------------
module smbus_pec_word_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  spw_chan_if.sink   rx_if,
  spw_chan_if.source res_if,
  spw_chan_if.sink   cfg_if
);
  import spw_pkg::*;

  logic [7:0] prefix_crc;

  assign cfg_if.ready = 1'b1;

  spw_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_item_i   (cfg_if.payload),
    .prefix_crc_o (prefix_crc)
  );

  spw_pec_core u_pec_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prefix_crc_i (prefix_crc),
    .in_valid_i   (rx_if.valid),
    .in_ready_o   (rx_if.ready),
    .in_item_i    (rx_if.payload),
    .out_valid_o  (res_if.valid),
    .out_ready_i  (res_if.ready),
    .out_item_o   (res_if.payload)
  );

endmodule

[hw/rtl/spw_checker.sv]
// ----------------------------------------------------------------------------
// spw_checker
// Port-level checks for the PEC checker, bound to the top level.
// ----------------------------------------------------------------------------
module spw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rx_valid_i,
  input logic               rx_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input spw_pkg::res_item_t res_item_i,
  input logic               cfg_ready_i
);
  import spw_pkg::*;

  // A result that is not taken stays offered.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // A mismatch always zeroes the word.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_item_i.pec_error |-> res_item_i.data_word == 16'h0000)
    else $error("data word not zero on PEC error");

  // A fresh result must be preceded by an accepted byte.
  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(rx_valid_i && rx_ready_i, 2))
    else $error("result without a matching accepted item");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind smbus_pec_word_checker_unit spw_checker u_spw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx_if.valid),
  .rx_ready_i  (rx_if.ready),
  .res_valid_i (res_if.valid),
  .res_ready_i (res_if.ready),
  .res_item_i  (res_if.payload),
  .cfg_ready_i (cfg_if.ready)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SMBus read-word PEC checker. A short table of
// directed responses is followed by random responses under several address
// and command settings, with random gaps and stalls on both channels. An
// in-bench CRC-8 predictor supplies the expected result of every PEC byte.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spw_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int NumPhases      = 8;
  localparam int ItemsPerPhase  = 62;
  localparam int SettleCycles   = 10;
  localparam int LongHoldCycles = 300;
  localparam int LongHoldAfter  = 200;
  localparam int NumDirected    = 24;

  typedef enum logic [1:0] {
    PEC_LITERAL,
    PEC_CORRECT,
    PEC_CORRUPT
  } pec_choice_e;

  // One directed byte. Only PEC rows may carry a typed expectation.
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        frame_start;
    pec_choice_e choice;
    logic        typed;
    logic [15:0] word;
    logic        err;
    logic        pec_typed;
    logic [7:0]  pec;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = ~clk_i;
  end

  spw_chan_if #(.payload_t(rx_item_t))  rx_if ();
  spw_chan_if #(.payload_t(res_item_t)) res_if ();
  spw_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  smbus_pec_word_checker_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_if  (rx_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  // Predictor state: registers as last written plus the response tracker.
  logic [6:0] m_addr;
  logic [7:0] m_cmd;
  logic [1:0] m_pos;
  logic [7:0] m_crc;
  logic [7:0] m_lo;
  logic [7:0] m_hi;

  res_item_t awaited_results[$];

  int  cycle_cnt  = 0;
  int  n_fail     = 0;
  int  n_rx       = 0;
  int  n_checked  = 0;
  int  n_pec_err  = 0;
  int  n_restart  = 0;
  int  n_settings = 1;
  bit  no_idle    = 1'b0;
  bit  held_long  = 1'b0;

  dir_row_t dir_tab [NumDirected] = '{
    // After reset: all-zero response under address 0, command 7.
    '{8'h00, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h62, 1'b0, PEC_LITERAL, 1'b1, 16'h0000, 1'b0, 1'b1, 8'h62},
    // All-ones data with a matching PEC.
    '{8'hFF, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, PEC_CORRECT, 1'b1, 16'hFFFF, 1'b0, 1'b0, 8'h00},
    // Corrupted PEC must zero the word and raise the error.
    '{8'h5A, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'hA5, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, PEC_CORRUPT, 1'b1, 16'h0000, 1'b1, 1'b0, 8'h00},
    // Restart where the high byte is due.
    '{8'h12, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h34, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h56, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, PEC_CORRECT, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    // Restart where the PEC byte is due.
    '{8'h11, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h22, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h33, 1'b1, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h44, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, PEC_CORRECT, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    // A low byte without frame_start still opens a response.
    '{8'h80, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h01, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'h00, 1'b0, PEC_CORRECT, 1'b1, 16'h0180, 1'b0, 1'b0, 8'h00},
    // All-ones PEC byte.
    '{8'h00, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00},
    '{8'hFF, 1'b0, PEC_LITERAL, 1'b0, 16'h0000, 1'b0, 1'b0, 8'h00}
  };

  // Bit-serial CRC-8, message bits MSB first.
  function automatic logic [7:0] crc_shift_in(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] header_crc(input logic [6:0] addr, input logic [7:0] cmd);
    logic [7:0] wr_addr;
    wr_addr = {addr, 1'b0};
    return crc_shift_in(crc_shift_in(crc_shift_in(8'h00, wr_addr), cmd), wr_addr);
  endfunction

  // Advances the tracker by one accepted byte; returns 1 when a result is due.
  function automatic bit predict_byte(input logic [7:0] b, input logic s, output res_item_t r);
    r = '0;
    if (s || m_pos == 2'd0 || m_pos == 2'd3) begin
      m_lo  = b;
      m_crc = crc_shift_in(header_crc(m_addr, m_cmd), b);
      m_pos = 2'd1;
      return 1'b0;
    end
    if (m_pos == 2'd1) begin
      m_hi  = b;
      m_crc = crc_shift_in(m_crc, b);
      m_pos = 2'd2;
      return 1'b0;
    end
    r.pec_error    = (b != m_crc);
    r.data_word    = r.pec_error ? 16'h0000 : {m_hi, m_lo};
    r.computed_pec = m_crc;
    m_pos          = 2'd0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_rx(input logic [7:0] b, input logic s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.payload <= '{rx_byte: b, frame_start: s};
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    n_rx++;
  endtask

  task automatic feed(input logic [7:0] b, input logic s);
    res_item_t r;
    if (s && m_pos != 2'd0) n_restart++;
    send_rx(b, s);
    if (predict_byte(b, s, r)) awaited_results.push_back(r);
  endtask

  // Completes any open response so that the block is idle afterwards.
  task automatic close_frame();
    while (m_pos == 2'd1 || m_pos == 2'd2) begin
      feed((m_pos == 2'd2) ? m_crc : rand_byte(), 1'b0);
    end
  endtask

  task automatic drain();
    rx_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [7:0] addr_data, input logic [7:0] cmd_data);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{index: REG_SLAVE_ADDRESS, wdata: addr_data};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.payload <= '{index: REG_COMMAND_CODE, wdata: cmd_data};
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    // Bit 7 of the address write is dropped by the register.
    m_addr = addr_data[6:0];
    m_cmd  = cmd_data;
    n_settings++;
  endtask

  // Receiver: random runs of ready and stall, plus one long hold-off.
  initial begin
    int run_left;
    run_left     = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!held_long && n_rx >= LongHoldAfter) begin
        held_long = 1'b1;
        res_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        run_left = 0;
      end else if (run_left == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          res_if.ready <= 1'b1;
          run_left = $urandom_range(1, 30);
        end else begin
          res_if.ready <= 1'b0;
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
        end
      end else begin
        run_left--;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    res_item_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result item: data_word %h pec_error %b computed_pec %h",
               res_if.payload.data_word, res_if.payload.pec_error,
               res_if.payload.computed_pec);
        n_fail++;
      end else begin
        want = awaited_results.pop_front();
        n_checked++;
        if (want.pec_error) n_pec_err++;
        if (res_if.payload.data_word !== want.data_word) begin
          $error("data_word expected %h actual %h", want.data_word, res_if.payload.data_word);
          n_fail++;
        end
        if (res_if.payload.pec_error !== want.pec_error) begin
          $error("pec_error expected %b actual %b", want.pec_error, res_if.payload.pec_error);
          n_fail++;
        end
        if (res_if.payload.computed_pec !== want.computed_pec) begin
          $error("computed_pec expected %h actual %h", want.computed_pec,
                 res_if.payload.computed_pec);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("smbus_pec_word_checker_unit verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t   row;
    res_item_t  r;
    logic [7:0] b;
    logic [7:0] addr_data;
    logic [7:0] cmd_data;

    rst_ni         = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    m_addr = AddrReset;
    m_cmd  = CmdReset;
    m_pos  = 2'd0;
    m_lo   = 8'h00;
    m_hi   = 8'h00;
    m_crc  = header_crc(AddrReset, CmdReset);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = dir_tab[i];
      case (row.choice)
        PEC_CORRECT: b = m_crc;
        PEC_CORRUPT: b = ~m_crc;
        default:     b = row.rx_byte;
      endcase
      send_rx(b, row.frame_start);
      if (predict_byte(b, row.frame_start, r)) begin
        if (row.typed) begin
          r.data_word = row.word;
          r.pec_error = row.err;
          if (row.pec_typed) r.computed_pec = row.pec;
        end
        awaited_results.push_back(r);
      end
    end
    close_frame();
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin addr_data = 8'hFF; cmd_data = 8'hFF; end
        1: begin addr_data = 8'h00; cmd_data = 8'h00; end
        2: begin addr_data = 8'h7F; cmd_data = 8'h00; end
        3: begin addr_data = 8'h80; cmd_data = 8'hFF; end
        default: begin addr_data = 8'($urandom); cmd_data = 8'($urandom); end
      endcase
      write_config(addr_data, cmd_data);
      no_idle = (ph == 5);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        case (m_pos)
          2'd1: feed(rand_byte(), ($urandom_range(0, 99) < 8));
          2'd2: begin
            if ($urandom_range(0, 99) < 8) feed(rand_byte(), 1'b1);
            else if ($urandom_range(0, 99) < 70) feed(m_crc, 1'b0);
            else feed(rand_byte(), 1'b0);
          end
          default: feed(rand_byte(), 1'($urandom_range(0, 1)));
        endcase
      end
      close_frame();
      drain();
    end

    $display("Sent %0d bytes over %0d address/command settings, %0d mid-response restarts.",
             n_rx, n_settings, n_restart);
    $display("Checked %0d results, %0d of them PEC mismatches; %0d field failures.",
             n_checked, n_pec_err, n_fail);
    if (n_fail == 0) begin
      $display("smbus_pec_word_checker_unit verification clean");
    end else begin
      $display("smbus_pec_word_checker_unit verification failed");
    end
    $finish;
  end

endmodule
